/* rtl/filename_to_rad50_encoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Filename to RAD50 encoder - assertion macros
// Shared property forms for the encoder checkers.
// ----------------------------------------------------------------------------
`ifndef FILENAME_TO_RAD50_ENCODER_TOP_MACROS_SVH
`define FILENAME_TO_RAD50_ENCODER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define FNR50_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fnr50 check failed");

// next-cycle implication, held off during reset
`define FNR50_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fnr50 check failed");

`endif

/* rtl/fnr50_pkg.sv */
// ----------------------------------------------------------------------------
// Filename to RAD50 encoder - package
// Constants, character map and word packing shared by the encoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fnr50_pkg;

    typedef logic [5:0]  code_t;
    typedef logic [3:0]  count_t;
    typedef logic [15:0] word_t;

    localparam int unsigned MAX_NAME_CHARS = 10;
    localparam int unsigned SLOT_COUNT     = 9;
    localparam int unsigned EXT_SLOT       = 6;
    localparam int unsigned DOT_LAST_POS   = 6;
    localparam int unsigned RADIX          = 40;
    localparam int unsigned COUNT_MAX      = 15;

    localparam code_t BAD_CODE    = 6'd63;
    localparam code_t CODE_DOLLAR = 6'd27;
    localparam code_t CODE_DOT    = 6'd28;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_BASE = 8'h40;
    localparam logic [7:0] LOWER_BASE = 8'h60;
    localparam logic [7:0] DIGIT_BASE = 8'h12;

    function automatic code_t code_of(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch == CH_SPACE) begin
            return 6'd0;
        end
        if (ch == CH_DOLLAR) begin
            return CODE_DOLLAR;
        end
        if (ch == CH_DOT) begin
            return CODE_DOT;
        end
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            diff = ch - UPPER_BASE;
            return diff[5:0];
        end
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            diff = ch - DIGIT_BASE;
            return diff[5:0];
        end
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            diff = ch - LOWER_BASE;
            return diff[5:0];
        end
        return BAD_CODE;
    endfunction

    function automatic word_t rad50_word(input code_t c0, input code_t c1, input code_t c2);
        word_t w;
        w = word_t'(c0) * word_t'(RADIX * RADIX)
          + word_t'(c1) * word_t'(RADIX)
          + word_t'(c2);
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/filename_to_rad50_encoder_top.sv */
// ----------------------------------------------------------------------------
// Filename to RAD50 encoder - top level
// Packs a file name, one character per transaction, into three RAD50 words.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  item      item_valid / item_stall     character[7:0], is_end
//  result    result_valid / result_stall name_word_high, name_word_low,
//                                        extension_word, name_invalid
//
//  One transaction per cycle on the item side while item_stall is low; a result
//  follows its end transaction through the input and result registers.
//  Input register, then slot update / word packing, then result register.
//  Only an end transaction waits for the result register to be free.
//  Reset clears the slots, counters and error flag; an end transaction does too.
`timescale 1ns / 1ps
`default_nettype none

module filename_to_rad50_encoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [7:0]  character,
    input  wire logic        is_end,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      name_word_high,
    output logic [15:0]      name_word_low,
    output logic [15:0]      extension_word,
    output logic             name_invalid
);

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_end_reg;

    fnr50_pkg::count_t     chars_seen_reg, chars_seen_next;
    fnr50_pkg::count_t     write_slot_reg, write_slot_next;
    logic                  sticky_reg, sticky_next;
    fnr50_pkg::code_t      slot_codes_reg [fnr50_pkg::SLOT_COUNT];
    fnr50_pkg::code_t      slot_codes_next [fnr50_pkg::SLOT_COUNT];

    logic                  out_valid_reg, out_valid_next;
    fnr50_pkg::word_t      word_high_reg, word_high_next;
    fnr50_pkg::word_t      word_low_reg, word_low_next;
    fnr50_pkg::word_t      word_ext_reg, word_ext_next;
    logic                  invalid_reg, invalid_next;

    logic                  out_free;
    logic                  fire;
    logic                  accept;
    logic                  bad_slot;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && (!in_end_reg || out_free);
    assign item_stall = in_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept || fire)
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= character;
            in_end_reg  <= is_end;
        end
    end

    always_comb
    begin
        bad_slot = 1'b0;
        for (int k = 0; k < fnr50_pkg::SLOT_COUNT; k++)
        begin
            if (slot_codes_reg[k] >= fnr50_pkg::code_t'(fnr50_pkg::RADIX))
            begin
                bad_slot = 1'b1;
            end
        end
    end

    always_comb
    begin
        chars_seen_next = chars_seen_reg;
        write_slot_next = write_slot_reg;
        sticky_next     = sticky_reg;
        slot_codes_next = slot_codes_reg;
        out_valid_next  = out_valid_reg && result_stall;
        word_high_next  = word_high_reg;
        word_low_next   = word_low_reg;
        word_ext_next   = word_ext_reg;
        invalid_next    = invalid_reg;

        if (fire)
        begin
            if (in_end_reg)
            begin
                out_valid_next = 1'b1;
                if (sticky_reg || bad_slot)
                begin
                    word_high_next = '0;
                    word_low_next  = '0;
                    word_ext_next  = '0;
                    invalid_next   = 1'b1;
                end
                else
                begin
                    word_high_next = fnr50_pkg::rad50_word(slot_codes_reg[0],
                        slot_codes_reg[1], slot_codes_reg[2]);
                    word_low_next  = fnr50_pkg::rad50_word(slot_codes_reg[3],
                        slot_codes_reg[4], slot_codes_reg[5]);
                    word_ext_next  = fnr50_pkg::rad50_word(slot_codes_reg[6],
                        slot_codes_reg[7], slot_codes_reg[8]);
                    invalid_next   = 1'b0;
                end
                chars_seen_next = '0;
                write_slot_next = '0;
                sticky_next     = 1'b0;
                for (int k = 0; k < fnr50_pkg::SLOT_COUNT; k++)
                begin
                    slot_codes_next[k] = '0;
                end
            end
            else
            begin
                if (chars_seen_reg >= fnr50_pkg::count_t'(fnr50_pkg::MAX_NAME_CHARS))
                begin
                    sticky_next = 1'b1;
                end
                else if (in_char_reg == fnr50_pkg::CH_DOT)
                begin
                    if (chars_seen_reg > fnr50_pkg::count_t'(fnr50_pkg::DOT_LAST_POS))
                    begin
                        sticky_next = 1'b1;
                    end
                    else
                    begin
                        write_slot_next = fnr50_pkg::count_t'(fnr50_pkg::EXT_SLOT);
                    end
                end
                else if (write_slot_reg >= fnr50_pkg::count_t'(fnr50_pkg::SLOT_COUNT))
                begin
                    sticky_next = 1'b1;
                end
                else
                begin
                    slot_codes_next[write_slot_reg] = fnr50_pkg::code_of(in_char_reg);
                    write_slot_next = write_slot_reg + 4'd1;
                end
                if (chars_seen_reg != fnr50_pkg::count_t'(fnr50_pkg::COUNT_MAX))
                begin
                    chars_seen_next = chars_seen_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_seen_reg <= '0;
            write_slot_reg <= '0;
            sticky_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < fnr50_pkg::SLOT_COUNT; k++)
            begin
                slot_codes_reg[k] <= '0;
            end
        end
        else
        begin
            chars_seen_reg <= chars_seen_next;
            write_slot_reg <= write_slot_next;
            sticky_reg     <= sticky_next;
            out_valid_reg  <= out_valid_next;
            slot_codes_reg <= slot_codes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_high_reg <= word_high_next;
        word_low_reg  <= word_low_next;
        word_ext_reg  <= word_ext_next;
        invalid_reg   <= invalid_next;
    end

    assign result_valid   = out_valid_reg;
    assign name_word_high = word_high_reg;
    assign name_word_low  = word_low_reg;
    assign extension_word = word_ext_reg;
    assign name_invalid   = invalid_reg;

endmodule

`default_nettype wire

/* rtl/fnr50_checker.sv */
// ----------------------------------------------------------------------------
// Filename to RAD50 encoder - port checker
// Watches the top-level ports and flags result transactions that break rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "filename_to_rad50_encoder_top_macros.svh"

module fnr50_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire logic        is_end,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [15:0] name_word_high,
    input wire logic [15:0] name_word_low,
    input wire logic [15:0] extension_word,
    input wire logic        name_invalid
);

    logic rejected;
    logic in_range;
    logic end_taken;

    assign rejected  = result_valid && name_invalid;
    assign in_range  = name_word_high <= 16'd63999 && name_word_low <= 16'd63999
                       && extension_word <= 16'd63999;
    assign end_taken = item_valid && !item_stall && is_end;

    `FNR50_ASSERT_IMPLY(a_reject_zero, clk, rst_n, rejected,
        name_word_high == 16'd0 && name_word_low == 16'd0 && extension_word == 16'd0)
    `FNR50_ASSERT_IMPLY(a_word_range, clk, rst_n, result_valid && !name_invalid, in_range)
    `FNR50_ASSERT_IMPLY(a_result_from_end, clk, rst_n, $rose(result_valid), $past(end_taken, 2))
    `FNR50_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(name_invalid) && $stable(name_word_high))

endmodule

bind filename_to_rad50_encoder_top fnr50_checker u_fnr50_checker (.*);

`default_nettype wire
